// ===== rtl/assert_macros.svh =====
// assertion macros used by the breathing led duty generator
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LBB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define LBB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define LBB_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LBB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/lbb_pkg.sv =====
// types and constants for the breathing led duty generator
// no dependencies
package lbb_pkg;

	localparam int unsigned DUTY_W = 16;
	localparam int unsigned CFG_W  = 8;
	localparam int unsigned CFG_IDX_W = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BREATH_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_DIVIDE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL     = 2'd2;

	localparam logic [7:0] TICK_DIVIDE_RESET = 8'd200;
	localparam logic [7:0] MIN_LEVEL_RESET   = 8'd3;

	// opcodes
	localparam logic OP_TICK      = 1'b0;
	localparam logic OP_SET_COLOR = 1'b1;

	localparam logic [8:0]  PHASE_TOP  = 9'd200;
	localparam logic [8:0]  PHASE_MID  = 9'd100;
	localparam logic [6:0]  ARC_RADIUS = 7'd100;
	localparam logic [13:0] ARC_RADIUS_SQ = 14'd10000;

	localparam int unsigned ROOT_W = 16;

	typedef struct packed {
		logic              opcode;
		logic [DUTY_W-1:0] red_in;
		logic [DUTY_W-1:0] green_in;
		logic [DUTY_W-1:0] blue_in;
	} in_item_t;

	typedef struct packed {
		logic [DUTY_W-1:0] red_duty;
		logic [DUTY_W-1:0] green_duty;
		logic [DUTY_W-1:0] blue_duty;
	} out_item_t;

endpackage

// ===== rtl/lbb_isqrt.sv =====
// iterative floor square root, one trial subtract per cycle
// depends on lbb_pkg
module lbb_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [13:0] radicand,
	output logic        busy,
	output logic        done,
	output logic [6:0]  root
);

	logic [lbb_pkg::ROOT_W-1:0] rem_q;
	logic [lbb_pkg::ROOT_W-1:0] root_q;
	logic [lbb_pkg::ROOT_W-1:0] bit_q;
	logic                       busy_q;
	logic                       done_q;
	logic [lbb_pkg::ROOT_W-1:0] trial;

	assign trial = root_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == lbb_pkg::ROOT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= lbb_pkg::ROOT_W'(radicand);
			root_q <= '0;
			bit_q  <= lbb_pkg::ROOT_W'(1) << 14;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q[6:0];

endmodule

// ===== rtl/led_breathing_brightness.sv =====
// breathing led duty generator: set-color passthrough and circular-arc breathing on blue
// depends on lbb_pkg, lbb_isqrt and assert_macros.svh
//
//   input channel (in_valid/in_stall/in_data) takes one transaction per item:
//   opcode set color or tick. output channel (out_valid/out_stall/out_data)
//   carries zero or one result per item. the block takes one item at a time
//   and holds in_stall high while an item is in work.
//   a set-color item is registered in res_q on acceptance and copied to the
//   output register from the hold state once it is free, which frees the input.
//   a tick that fires a phase step squares the distance, runs the iterative
//   root unit (one trial subtract a cycle), waits for its done flag and does
//   the min-level compare; a level at or above min_level goes through the hold
//   state to the output register, after which the next item goes in. a step
//   that lands below min_level ends with no result, and the midpoint step
//   skips the root unit with level zero. ticks that only bump the prescaler or
//   wrap the phase, and all ticks while breathing is off, give no result.
//   a stalled result holds in the output register while the next item is
//   accepted and computed; that item then waits for the register to free.
//   reset clears both counters, disables breathing, sets tick_divide to 200
//   and min_level to 3; configuration writes are expected only while idle.
`include "assert_macros.svh"
module led_breathing_brightness (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  lbb_pkg::in_item_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output lbb_pkg::out_item_t                 out_data,
	input  logic                               cfg_we,
	input  logic [lbb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lbb_pkg::CFG_W-1:0]          cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQ   = 3'd1;
	localparam logic [2:0] ST_ROOT = 3'd2;
	localparam logic [2:0] ST_LVL  = 3'd3;
	localparam logic [2:0] ST_HOLD = 3'd4;

	logic [2:0]         state_q;
	logic               breath_enable_q;
	logic [7:0]         tick_divide_q;
	logic [7:0]         min_level_q;
	logic [7:0]         prescale_q;
	logic [7:0]         phase_q;
	logic [6:0]         dist_q;
	logic [7:0]         level_q;
	lbb_pkg::out_item_t res_q;
	lbb_pkg::out_item_t out_q;
	logic               out_valid_q;

	logic        accept;
	logic [7:0]  pre_next;
	logic [8:0]  phase_next;
	logic [8:0]  dist_hi;
	logic [13:0] dist_sq;
	logic [13:0] radicand;
	logic        sq_start;
	logic        sq_busy;
	logic        sq_done;
	logic [6:0]  sq_root;
	logic        out_free;

	assign accept     = in_valid && !in_stall;
	assign in_stall   = (state_q != ST_IDLE);
	assign pre_next   = prescale_q + 8'd1;
	assign phase_next = {1'b0, phase_q} + 9'd1;
	assign dist_hi    = lbb_pkg::PHASE_TOP - phase_next;
	assign dist_sq    = 14'(dist_q) * 14'(dist_q);
	assign radicand   = lbb_pkg::ARC_RADIUS_SQ - dist_sq;
	assign sq_start   = (state_q == ST_SQ);
	assign out_free   = !out_valid_q || !out_stall;

	lbb_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (radicand),
		.busy     (sq_busy),
		.done     (sq_done),
		.root     (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			breath_enable_q <= 1'b0;
			tick_divide_q   <= lbb_pkg::TICK_DIVIDE_RESET;
			min_level_q     <= lbb_pkg::MIN_LEVEL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lbb_pkg::CFG_BREATH_ENABLE: breath_enable_q <= cfg_data[0];
				lbb_pkg::CFG_TICK_DIVIDE:   tick_divide_q   <= cfg_data;
				lbb_pkg::CFG_MIN_LEVEL:     min_level_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			prescale_q <= '0;
			phase_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_data.opcode == lbb_pkg::OP_SET_COLOR) begin
							state_q <= ST_HOLD;
						end else if (breath_enable_q) begin
							if (pre_next < tick_divide_q) begin
								prescale_q <= pre_next;
							end else begin
								prescale_q <= '0;
								if (phase_next > lbb_pkg::PHASE_TOP) begin
									phase_q <= '0;
								end else begin
									phase_q <= phase_next[7:0];
									if (phase_next == lbb_pkg::PHASE_MID) begin
										state_q <= ST_LVL;
									end else begin
										state_q <= ST_SQ;
									end
								end
							end
						end
					end
				end
				ST_SQ:   state_q <= ST_ROOT;
				ST_ROOT: begin
					if (sq_done) begin
						state_q <= ST_LVL;
					end
				end
				ST_LVL: begin
					if (level_q < min_level_q) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			res_q.red_duty   <= in_data.red_in;
			res_q.green_duty <= in_data.green_in;
			res_q.blue_duty  <= in_data.blue_in;
			level_q          <= '0;
			if (phase_next < lbb_pkg::PHASE_MID) begin
				dist_q <= phase_next[6:0];
			end else begin
				dist_q <= dist_hi[6:0];
			end
		end else if (state_q == ST_ROOT && sq_done) begin
			level_q <= 8'(lbb_pkg::ARC_RADIUS - sq_root);
		end else if (state_q == ST_LVL) begin
			res_q.red_duty   <= '0;
			res_q.green_duty <= '0;
			res_q.blue_duty  <= lbb_pkg::DUTY_W'(level_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_HOLD && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_HOLD && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`LBB_ASSERT_IMPLY(a_phase_range, clk, arst_n, 1'b1, {1'b0, phase_q} <= lbb_pkg::PHASE_TOP)
	`LBB_ASSERT_IMPLY(a_root_busy, clk, arst_n, state_q == ST_ROOT && !sq_done, sq_busy)
	`LBB_ASSERT_IMPLY(a_level_range, clk, arst_n, state_q == ST_LVL, level_q <= 8'd100)
	`LBB_ASSERT_NEXT(a_hold_emits, clk, arst_n, state_q == ST_HOLD && out_free, out_valid)

endmodule

// ===== tb/lbb_duty_checker.sv =====
// checker for the breathing led duty generator: predicts each result and compares it
// depends on lbb_pkg; watches the input, output and configuration ports of the block
module lbb_duty_checker
	import lbb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  in_item_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   errors,
	output int                   pending
);

	logic       breath_on;
	logic [7:0] divide;
	logic [7:0] floor_lvl;
	logic [7:0] prescale;
	logic [7:0] phase;

	out_item_t expected_duty[$];
	out_item_t want;
	out_item_t got;
	out_item_t next_duty;
	bit        emit;

	function automatic int unsigned int_root(int unsigned v);
		int unsigned r;
		r = 0;
		while ((r + 1) * (r + 1) <= v)
			r++;
		return r;
	endfunction

	// advances the prescaler and phase for a tick while breathing is on, and builds the transaction's result
	task automatic predict_duty(input in_item_t it, output bit has, output out_item_t res);
		logic [7:0]  nxt;
		int unsigned ph;
		int unsigned span;
		int unsigned lvl;
		has = 1'b0;
		res = '0;
		if (it.opcode == OP_SET_COLOR) begin
			res.red_duty   = it.red_in;
			res.green_duty = it.green_in;
			res.blue_duty  = it.blue_in;
			has = 1'b1;
		end else if (breath_on) begin
			nxt = prescale + 8'd1;
			if (nxt < divide) begin
				prescale = nxt;
			end else begin
				prescale = '0;
				ph = int'(phase) + 1;
				if (ph > PHASE_TOP) begin
					phase = '0;
				end else begin
					phase = ph[7:0];
					if (ph == PHASE_MID) begin
						lvl = 0;
					end else begin
						span = (ph < PHASE_MID) ? ph : PHASE_TOP - ph;
						lvl = ARC_RADIUS - int_root(ARC_RADIUS_SQ - span * span);
					end
					if (lvl >= floor_lvl) begin
						res.blue_duty = lvl[DUTY_W-1:0];
						has = 1'b1;
					end
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			breath_on = 1'b0;
			divide    = TICK_DIVIDE_RESET;
			floor_lvl = MIN_LEVEL_RESET;
			prescale  = '0;
			phase     = '0;
			expected_duty.delete();
			errors  = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BREATH_ENABLE: breath_on = cfg_data[0];
					CFG_TICK_DIVIDE:   divide = cfg_data;
					CFG_MIN_LEVEL:     floor_lvl = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got = out_data;
				if (expected_duty.size() == 0) begin
					$error("unexpected result red %0d green %0d blue %0d",
						got.red_duty, got.green_duty, got.blue_duty);
					errors++;
				end else begin
					want = expected_duty.pop_front();
					if (got.red_duty !== want.red_duty) begin
						$error("red_duty expected %0d actual %0d", want.red_duty, got.red_duty);
						errors++;
					end
					if (got.green_duty !== want.green_duty) begin
						$error("green_duty expected %0d actual %0d",
							want.green_duty, got.green_duty);
						errors++;
					end
					if (got.blue_duty !== want.blue_duty) begin
						$error("blue_duty expected %0d actual %0d", want.blue_duty, got.blue_duty);
						errors++;
					end
				end
			end
			// pop before push: a result never belongs to the transaction taken at the same edge
			if (in_valid && !in_stall) begin
				predict_duty(in_data, emit, next_duty);
				if (emit)
					expected_duty.push_back(next_duty);
			end
			pending <= expected_duty.size();
		end
	end

endmodule

// ===== tb/led_breathing_brightness_test.sv =====
// testbench top for the breathing led duty generator: clock, reset, stimulus and verdict
// depends on lbb_pkg, led_breathing_brightness and lbb_duty_checker
module led_breathing_brightness_test;
	import lbb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 24;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	int                   errors;
	int                   pending;
	int                   cycle_cnt = 0;
	int                   stall_left = 0;
	bit                   idle_on = 1'b1;

	led_breathing_brightness i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lbb_duty_checker i_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("led_breathing_brightness: mismatch");
			$finish;
		end
	end

	// receiver stalls in random bursts, started only while idle_on is set and reset is released
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (idle_on && arst_n && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_item(input in_item_t it);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_color(input logic [15:0] r, input logic [15:0] g, input logic [15:0] b);
		in_item_t it;
		it.opcode   = OP_SET_COLOR;
		it.red_in   = r;
		it.green_in = g;
		it.blue_in  = b;
		send_item(it);
	endtask

	task automatic send_tick();
		in_item_t it;
		it.opcode   = OP_TICK;
		it.red_in   = 16'($urandom);
		it.green_in = 16'($urandom);
		it.blue_in  = 16'($urandom);
		send_item(it);
	endtask

	// hold off until every outstanding result is out and the block has gone quiet
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic en, input logic [7:0] div, input logic [7:0] lvl);
		settle();
		write_reg(CFG_BREATH_ENABLE, {7'd0, en});
		write_reg(CFG_TICK_DIVIDE, div);
		write_reg(CFG_MIN_LEVEL, lvl);
	endtask

	task automatic run_random(input int n, input int tick_pct);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < tick_pct)
				send_tick();
			else
				send_color(16'($urandom), 16'($urandom), 16'($urandom));
			if ($urandom_range(0, 199) == 0)
				settle();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, breathing off
		send_color(16'h0000, 16'h0000, 16'h0000);
		send_color(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_color(16'hAAAA, 16'h5555, 16'h0F0F);
		send_tick();
		send_tick();
		send_color(16'h8000, 16'h0001, 16'h7FFF);

		// divide of zero steps the phase on every tick
		configure(1'b1, 8'd0, 8'd0);
		send_tick();
		send_tick();
		send_tick();
		send_color(16'h1234, 16'hFFFF, 16'h0000);
		send_tick();

		configure(1'b1, 8'd1, 8'd255);
		send_tick();
		send_tick();

		configure(1'b1, 8'd3, 8'd1);
		repeat (4) send_tick();
		send_color(16'h5555, 16'hAAAA, 16'hF0F0);

		// full breathing periods, level-zero results at the midpoint and the top, and the wrap
		configure(1'b1, 8'd1, 8'd0);
		run_random(420, 90);
		configure(1'b1, 8'd2, 8'd3);
		run_random(150, 85);
		configure(1'b1, 8'd255, 8'd255);
		run_random(200, 85);
		configure(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		run_random(100, 50);
		idle_on = 1'b0;
		configure(1'b1, 8'($urandom_range(0, 8)), 8'($urandom_range(0, 40)));
		run_random(200, 85);
		idle_on = 1'b1;
		configure(1'b1, 8'd0, 8'd1);
		run_random(200, 85);
		idle_on = 1'b0;
		configure(1'b1, 8'd1, 8'd10);
		run_random(150, 85);

		settle();
		if (errors == 0 && pending == 0)
			$display("led_breathing_brightness: match");
		else
			$display("led_breathing_brightness: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lbb_pkg.sv
rtl/lbb_isqrt.sv
rtl/led_breathing_brightness.sv
tb/lbb_duty_checker.sv
tb/led_breathing_brightness_test.sv
